FILE: hw/rtl/srclex_pkg.sv
// shared types, token codes and keyword table for the source lexer
`default_nettype none

package srclex_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int KEYWORD_CHARS_DEF = 6;

  localparam int FIELD_BITS  = 16;
  localparam int KIND_BITS   = 6;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_TOKENS  = 4;
  localparam int NUM_CANDS   = 6;
  localparam int NUM_KEYWORDS = 14;
  localparam int KW_TEXT_BITS = 48;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  typedef logic [KIND_BITS-1:0] kind_t;

  // token kinds
  localparam kind_t TK_LEFT_PAREN    = 6'd0;
  localparam kind_t TK_RIGHT_PAREN   = 6'd1;
  localparam kind_t TK_LEFT_BRACE    = 6'd2;
  localparam kind_t TK_RIGHT_BRACE   = 6'd3;
  localparam kind_t TK_COMMA         = 6'd4;
  localparam kind_t TK_DOT           = 6'd5;
  localparam kind_t TK_MINUS         = 6'd6;
  localparam kind_t TK_PLUS          = 6'd7;
  localparam kind_t TK_SEMICOLON     = 6'd8;
  localparam kind_t TK_STAR          = 6'd9;
  localparam kind_t TK_BANG          = 6'd10;
  localparam kind_t TK_EQUAL         = 6'd12;
  localparam kind_t TK_LESS          = 6'd14;
  localparam kind_t TK_GREATER       = 6'd16;
  localparam kind_t TK_SLASH         = 6'd18;
  localparam kind_t TK_STRING        = 6'd19;
  localparam kind_t TK_NUMBER        = 6'd20;
  localparam kind_t TK_IDENTIFIER    = 6'd21;
  localparam kind_t TK_KEYWORD0      = 6'd22;
  localparam kind_t TK_NIL           = 6'd28;
  localparam kind_t TK_SUPER         = 6'd31;
  localparam kind_t TK_OR            = 6'd36;
  localparam kind_t TK_AND           = 6'd37;
  localparam kind_t TK_EOF           = 6'd38;

  // characters
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_LESS       = 8'h3C;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_BAR        = 8'h7C;
  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  typedef enum logic [7:0] {
    MODE_IDLE     = 8'b0000_0001,
    MODE_OP       = 8'b0000_0010,
    MODE_COMMENT  = 8'b0000_0100,
    MODE_STRING   = 8'b0000_1000,
    MODE_NUM_INT  = 8'b0001_0000,
    MODE_NUM_DOT  = 8'b0010_0000,
    MODE_NUM_FRAC = 8'b0100_0000,
    MODE_IDENT    = 8'b1000_0000
  } lex_mode_t;

  typedef struct packed {
    kind_t                 kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] len;
    logic [FIELD_BITS-1:0] line;
    logic                  unterm;
    logic                  last;
  } tok_t;

  // keywords, first character in the lowest byte, in token code order
  localparam logic [KW_TEXT_BITS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    48'h0073_7361_6C63,  // class
    48'h0000_6573_6C65,  // else
    48'h0065_736C_6166,  // false
    48'h0000_0072_6F66,  // for
    48'h0000_006E_7566,  // fun
    48'h0000_0000_6669,  // if
    48'h0000_006C_696E,  // nil
    48'h0074_6E69_7270,  // print
    48'h6E72_7574_6572,  // return
    48'h0072_6570_7573,  // super
    48'h0000_7369_6874,  // this
    48'h0000_6575_7274,  // true
    48'h0000_0072_6176,  // var
    48'h0065_6C69_6877   // while
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd5, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd3, 4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5
  };

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  // operator held alone, without its partner
  function automatic kind_t single_kind(input logic [7:0] op);
    kind_t k;
    unique case (op)
      CH_BANG:    k = TK_BANG;
      CH_EQUAL:   k = TK_EQUAL;
      CH_LESS:    k = TK_LESS;
      CH_GREATER: k = TK_GREATER;
      CH_BAR:     k = TK_NIL;
      CH_AMP:     k = TK_SUPER;
      default:    k = TK_SLASH;
    endcase
    return k;
  endfunction

  // one-character punctuation; bit 6 flags a match
  function automatic logic [KIND_BITS:0] punct_kind(input logic [7:0] b);
    logic [KIND_BITS:0] r;
    unique case (b)
      CH_LPAREN:    r = {1'b1, TK_LEFT_PAREN};
      CH_RPAREN:    r = {1'b1, TK_RIGHT_PAREN};
      CH_LBRACE:    r = {1'b1, TK_LEFT_BRACE};
      CH_RBRACE:    r = {1'b1, TK_RIGHT_BRACE};
      CH_COMMA:     r = {1'b1, TK_COMMA};
      CH_DOT:       r = {1'b1, TK_DOT};
      CH_MINUS:     r = {1'b1, TK_MINUS};
      CH_PLUS:      r = {1'b1, TK_PLUS};
      CH_SEMICOLON: r = {1'b1, TK_SEMICOLON};
      CH_STAR:      r = {1'b1, TK_STAR};
      default:      r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/source_lexer_unit.sv
// source lexer: byte stream in, token stream out through a small queue
//
// Usage:
//   s_axis carries one source byte per request; tlast marks the final byte of
//   a source, which flushes any held token and closes the stream with an EOF
//   token. m_axis carries one token per request, tlast set on the EOF token.
//   An accepted byte lands in the input register and is scanned from there
//   once the queue has room; the tokens it completes enter an eight-entry
//   queue, whose head is offered on m_axis. Tokens that need a following
//   byte to be decided (operators, numbers, words) come out with the byte
//   that settles them.
//   Throughput: one byte per cycle while the queue has room for four more
//   tokens, the most a single byte can complete; the output side drains one
//   token per cycle while the receiver is ready, so a run of bytes that each
//   complete several tokens is paced by the output port.
//   When the receiver stalls the queue fills, the input register holds its
//   byte and s_axis_tready drops; nothing is lost.
//   Reset empties the queue and input register and returns the scanner to
//   the start of a source at line one; each EOF resets the scanner alone.
`default_nettype none

module source_lexer_unit
  import srclex_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] source_byte
  input  wire logic        s_axis_tlast,   // end_of_source
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [15:0] lexeme_start, [31:16] lexeme_length,
                                           // [47:32] line_number
  output logic [6:0]       m_axis_tuser,   // [5:0] token_kind, [6] unterminated
  output logic             m_axis_tlast    // last_token
);

  localparam int PREFIX_BITS = 8 * KEYWORD_CHARS;
  localparam int WLEN_BITS   = $clog2(KEYWORD_CHARS + 2);
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } flush_t;

  // lexer state
  lex_mode_t             lex_mode, lex_mode_next;
  logic [7:0]            pending_operator, pending_operator_next;
  pos_t                  token_start, token_start_next;
  pos_t                  byte_position, byte_position_next;
  logic [15:0]           line_count, line_count_next;
  logic [PREFIX_BITS-1:0] word_prefix, word_prefix_next;
  logic [WLEN_BITS-1:0]  word_length, word_length_next;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       process;

  // token queue
  tok_t                  fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic                  pop;
  logic [FIFO_CNT_W-1:0] push_count;

  logic                  cand_valid [NUM_CANDS];
  tok_t                  cand       [NUM_CANDS];
  logic [2:0]            cand_off   [NUM_CANDS];

  function automatic logic [FIELD_BITS-1:0] to_field(input pos_t p);
    logic [31:0] w;
    w = 32'(p);
    return w[FIELD_BITS-1:0];
  endfunction

  function automatic tok_t make_tok(input kind_t k, input pos_t s, input pos_t l,
                                    input logic [15:0] ln, input logic u, input logic e);
    tok_t t;
    t.kind   = k;
    t.start  = to_field(s);
    t.len    = to_field(l);
    t.line   = ln;
    t.unterm = u;
    t.last   = e;
    return t;
  endfunction

  function automatic kind_t word_kind(input logic [PREFIX_BITS-1:0] prefix,
                                      input logic [WLEN_BITS-1:0] wlen);
    kind_t k;
    k = TK_IDENTIFIER;
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      if ((32'(wlen) == 32'(KW_LEN[i])) && (32'(KW_LEN[i]) <= KEYWORD_CHARS) &&
          (prefix == PREFIX_BITS'(KW_TEXT[i]))) begin
        k = TK_KEYWORD0 + KIND_BITS'(i);
      end
    end
    return k;
  endfunction

  // held token whose lexeme ends just before stop
  function automatic flush_t flush_tok(input lex_mode_t m, input logic [7:0] op,
                                       input pos_t ts, input pos_t stop,
                                       input logic [PREFIX_BITS-1:0] prefix,
                                       input logic [WLEN_BITS-1:0] wlen,
                                       input logic [15:0] ln);
    flush_t f;
    pos_t   dotp;
    f    = '0;
    dotp = (stop > ts) ? stop - pos_t'(1) : ts;
    unique case (m) inside
      MODE_OP: begin
        f.v0 = 1'b1;
        f.t0 = make_tok(single_kind(op), ts, pos_t'(1), ln, 1'b0, 1'b0);
      end
      MODE_STRING: begin
        f.v0 = 1'b1;
        f.t0 = make_tok(TK_STRING, ts, stop - ts, ln, 1'b1, 1'b0);
      end
      MODE_NUM_INT, MODE_NUM_FRAC: begin
        f.v0 = 1'b1;
        f.t0 = make_tok(TK_NUMBER, ts, stop - ts, ln, 1'b0, 1'b0);
      end
      MODE_NUM_DOT: begin
        // dot with no digit after it is its own token
        f.v0 = 1'b1;
        f.t0 = make_tok(TK_NUMBER, ts, dotp - ts, ln, 1'b0, 1'b0);
        f.v1 = 1'b1;
        f.t1 = make_tok(TK_DOT, dotp, pos_t'(1), ln, 1'b0, 1'b0);
      end
      MODE_IDENT: begin
        f.v0 = 1'b1;
        f.t0 = make_tok(word_kind(prefix, wlen), ts, stop - ts, ln, 1'b0, 1'b0);
      end
      default: begin
        f.v0 = 1'b0;
      end
    endcase
    return f;
  endfunction

  // scan one byte
  always_comb begin
    logic [7:0]         b;
    pos_t               end_pos;
    logic [15:0]        line_inc;
    logic               fresh;
    logic [7:0]         partner;
    flush_t             fa;
    flush_t             fl;
    logic [KIND_BITS:0] pk;
    lex_mode_t          m;
    logic [7:0]         op;
    pos_t               ts;
    logic [PREFIX_BITS-1:0] pre;
    logic [WLEN_BITS-1:0]   wl;
    logic [2:0]         run;

    b        = in_byte;
    end_pos  = (byte_position == POS_MAX) ? byte_position : byte_position + pos_t'(1);
    line_inc = ((b == CH_NEWLINE) && (line_count != LINE_MAX)) ? line_count + 16'd1
                                                                : line_count;
    fresh    = 1'b0;
    m        = lex_mode;
    op       = pending_operator;
    ts       = token_start;
    pre      = word_prefix;
    wl       = word_length;
    partner  = ((pending_operator == CH_BANG) || (pending_operator == CH_EQUAL) ||
                (pending_operator == CH_LESS) || (pending_operator == CH_GREATER))
               ? CH_EQUAL : pending_operator;
    fa       = flush_tok(lex_mode, pending_operator, token_start, byte_position,
                         word_prefix, word_length, line_count);
    for (int c = 0; c < NUM_CANDS; c++) begin
      cand_valid[c] = 1'b0;
      cand[c]       = '0;
    end

    unique case (lex_mode)
      MODE_OP: begin
        if (b == partner) begin
          m = MODE_IDLE;
          if (pending_operator == CH_SLASH) begin
            m = MODE_COMMENT;
          end else begin
            cand_valid[0] = 1'b1;
            cand[0] = make_tok((pending_operator == CH_BAR) ? TK_OR :
                               (pending_operator == CH_AMP) ? TK_AND :
                               single_kind(pending_operator) + kind_t'(1),
                               token_start, end_pos - token_start, line_count, 1'b0, 1'b0);
          end
        end else begin
          fresh = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (b == CH_NEWLINE) m = MODE_IDLE;
      end
      MODE_STRING: begin
        if (b == CH_QUOTE) begin
          m = MODE_IDLE;
          cand_valid[0] = 1'b1;
          cand[0] = make_tok(TK_STRING, token_start, end_pos - token_start, line_count,
                             1'b0, 1'b0);
        end
      end
      MODE_NUM_INT: begin
        if (b == CH_DOT) m = MODE_NUM_DOT;
        else if (!is_digit(b)) fresh = 1'b1;
      end
      MODE_NUM_DOT: begin
        if (is_digit(b)) m = MODE_NUM_FRAC;
        else fresh = 1'b1;
      end
      MODE_NUM_FRAC: begin
        if (!is_digit(b)) fresh = 1'b1;
      end
      MODE_IDENT: begin
        if (is_alpha(b) || (b == CH_UNDERSCORE)) begin
          for (int i = 0; i < KEYWORD_CHARS; i++) begin
            if (32'(word_length) == i) pre[8*i +: 8] = b;
          end
          if (32'(word_length) <= KEYWORD_CHARS) wl = word_length + WLEN_BITS'(1);
        end else begin
          fresh = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // a held token flushed by this byte, in modes that allow it
    if (fresh && (lex_mode != MODE_IDLE)) begin
      cand_valid[0] = fa.v0;
      cand[0]       = fa.t0;
      cand_valid[1] = fa.v1;
      cand[1]       = fa.t1;
    end

    // start of a new token
    pk = punct_kind(b);
    if (fresh) begin
      ts = byte_position;
      m  = MODE_IDLE;
      if (pk[KIND_BITS]) begin
        cand_valid[2] = 1'b1;
        cand[2] = make_tok(pk[KIND_BITS-1:0], byte_position, pos_t'(1), line_count,
                           1'b0, 1'b0);
      end else if ((b == CH_BANG) || (b == CH_EQUAL) || (b == CH_LESS) ||
                   (b == CH_GREATER) || (b == CH_SLASH) || (b == CH_BAR) ||
                   (b == CH_AMP)) begin
        m  = MODE_OP;
        op = b;
      end else if (b == CH_QUOTE) begin
        m = MODE_STRING;
      end else if (is_digit(b)) begin
        m = MODE_NUM_INT;
      end else if (is_alpha(b)) begin
        m   = MODE_IDENT;
        pre = PREFIX_BITS'(b);
        wl  = WLEN_BITS'(1);
      end
    end

    // end of source: flush and close
    fl = flush_tok(m, op, ts, end_pos, pre, wl, line_inc);
    if (in_last) begin
      cand_valid[3] = fl.v0;
      cand[3]       = fl.t0;
      cand_valid[4] = fl.v1;
      cand[4]       = fl.t1;
      cand_valid[5] = 1'b1;
      cand[5]       = make_tok(TK_EOF, end_pos, pos_t'(0), line_inc, 1'b0, 1'b1);
    end

    run = '0;
    for (int c = 0; c < NUM_CANDS; c++) begin
      cand_off[c] = run;
      if (cand_valid[c]) run = run + 3'd1;
    end
    push_count = (run > 3'(MAX_TOKENS)) ? FIFO_CNT_W'(MAX_TOKENS) : FIFO_CNT_W'(run);

    if (in_last) begin
      lex_mode_next         = MODE_IDLE;
      pending_operator_next = '0;
      token_start_next      = '0;
      byte_position_next    = '0;
      line_count_next       = 16'd1;
      word_prefix_next      = '0;
      word_length_next      = '0;
    end else begin
      lex_mode_next         = m;
      pending_operator_next = op;
      token_start_next      = ts;
      byte_position_next    = end_pos;
      line_count_next       = line_inc;
      word_prefix_next      = pre;
      word_length_next      = wl;
    end
  end

  assign process       = in_valid && (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - MAX_TOKENS));
  assign s_axis_tready = !in_valid || process;
  assign m_axis_tvalid = (fifo_count != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode         <= MODE_IDLE;
      pending_operator <= '0;
      token_start      <= '0;
      byte_position    <= '0;
      line_count       <= 16'd1;
      word_prefix      <= '0;
      word_length      <= '0;
    end else if (process) begin
      lex_mode         <= lex_mode_next;
      pending_operator <= pending_operator_next;
      token_start      <= token_start_next;
      byte_position    <= byte_position_next;
      line_count       <= line_count_next;
      word_prefix      <= word_prefix_next;
      word_length      <= word_length_next;
    end
  end

  // queue: up to four writes per cycle at consecutive slots
  always_ff @(posedge clk) begin
    if (process) begin
      for (int c = 0; c < NUM_CANDS; c++) begin
        if (cand_valid[c] && (cand_off[c] < 3'(MAX_TOKENS))) begin
          fifo_mem[FIFO_PTR_W'(wr_ptr + FIFO_PTR_W'(cand_off[c]))] <= cand[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (process) wr_ptr <= FIFO_PTR_W'(wr_ptr + FIFO_PTR_W'(push_count));
      if (pop) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      fifo_count <= fifo_count + (process ? push_count : '0)
                    - (pop ? FIFO_CNT_W'(1) : '0);
    end
  end

  always_comb begin
    tok_t head;
    head          = fifo_mem[rd_ptr];
    m_axis_tdata  = {head.line, head.len, head.start};
    m_axis_tuser  = {head.unterm, head.kind};
    m_axis_tlast  = head.last;
  end

endmodule

`default_nettype wire
